>>> src/mahs_pkg.sv
// Shared types, constants and lookup tables for the MPEG audio header sync block.
`default_nettype none
package mahs_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int JOB_DEPTH      = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_SEARCH   = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MATCH_RATE   = 2'd2;

   localparam logic [15:0] MAX_SEARCH_RESET = 16'd4096;
   localparam logic [15:0] MATCH_RATE_RESET = 16'd44100;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SYNC_MASK = 8'hE0;

   localparam logic [1:0] LEVEL_MPEG1  = 2'd1;
   localparam logic [1:0] LEVEL_MPEG2  = 2'd2;
   localparam logic [1:0] LEVEL_MPEG25 = 2'd3;

   localparam logic [1:0] LAYER_1 = 2'd1;
   localparam logic [1:0] LAYER_2 = 2'd2;
   localparam logic [1:0] LAYER_3 = 2'd3;

   localparam logic [10:0] SPF_LAYER1 = 11'd384;
   localparam logic [10:0] SPF_LONG   = 11'd1152;
   localparam logic [10:0] SPF_SHORT  = 11'd576;

   localparam logic [17:0] COEF_LAYER1 = 18'd12000;
   localparam logic [17:0] COEF_SHORT  = 18'd72000;
   localparam logic [17:0] COEF_LONG   = 18'd144000;

   localparam int NUM_BITS = 27;

   localparam logic [15:0] RATE_V1 [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
   localparam logic [15:0] RATE_V2 [4] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};

   localparam logic [8:0] KBPS_TAB [6][16] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
   };

   typedef struct packed {
      logic [7:0] byte_in;
      logic       first;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [15:0] offset;
      logic [1:0]  version_level;
      logic [1:0]  layer;
      logic        crc_present;
      logic        padding;
      logic        private_bit;
      logic [3:0]  mode_bits;
      logic [15:0] sample_rate;
      logic [8:0]  bitrate_kbps;
      logic [10:0] samples_per_frame;
      logic [12:0] frame_bytes;
   } rsp_type;

   function automatic logic [15:0] rate_lookup(input logic [1:0] level,
                                               input logic [1:0] fq);
      logic [15:0] r;
      case (level)
         LEVEL_MPEG1:  r = RATE_V1[fq];
         LEVEL_MPEG2:  r = RATE_V2[fq];
         LEVEL_MPEG25: r = RATE_V2[fq] >> 1;
         default:      r = 16'd0;
      endcase
      return r;
   endfunction

   function automatic logic [8:0] kbps_lookup(input logic [2:0] row,
                                              input logic [3:0] idx);
      logic [8:0] k;
      if (row < 3'd6) begin
         k = KBPS_TAB[row][idx];
      end else begin
         k = 9'd0;
      end
      return k;
   endfunction

endpackage
`default_nettype wire

>>> src/mahs_front.sv
// Front part: byte window, search control, header classification and config registers.
`default_nettype none
module mahs_front #(
   parameter int COUNT_BITS = mahs_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_push,
   input  wire mahs_pkg::req_type                     req_data,
   input  wire logic                                  csr_we,
   input  wire logic [mahs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [mahs_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic                                  job_full,
   output logic                                       job_push,
   output mahs_pkg::rsp_type                          job_data
);
   import mahs_pkg::*;

   localparam int LW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
   localparam logic [LW-1:0] CAP = {{(LW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}} - LW'(3);

   logic [15:0]           max_search_ff, max_search_in;
   logic                  match_enable_ff, match_enable_in;
   logic [15:0]           match_rate_ff, match_rate_in;
   logic [23:0]           window_ff, window_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  searching_ff, searching_in;

   logic                  accept;
   logic                  srch;
   logic [COUNT_BITS-1:0] cnt;
   logic [23:0]           win;
   logic [COUNT_BITS-1:0] pos;
   logic [LW-1:0]         pos_ext, ms_ext, lim0, limit;
   logic [7:0]            b0, b1, b2, b3;
   logic [1:0]            level, layer;
   logic [2:0]            row;
   logic [15:0]           rate;
   logic [8:0]            kbps;
   logic                  hdr_ok;
   rsp_type               hit_job;

   assign accept = req_push & ~job_full;

   always_comb begin
      srch    = req_data.first | searching_ff;
      cnt     = req_data.first ? '0 : count_ff;
      win     = req_data.first ? 24'd0 : window_ff;
      pos     = cnt - COUNT_BITS'(3);
      pos_ext = LW'(pos);
      ms_ext  = LW'(max_search_ff);
      lim0    = (ms_ext < LW'(5)) ? '0 : ms_ext - LW'(5);
      limit   = (lim0 > CAP) ? CAP : lim0;

      b0 = win[23:16];
      b1 = win[15:8];
      b2 = win[7:0];
      b3 = req_data.byte_in;

      case (b1[4:3])
         2'b11:   level = LEVEL_MPEG1;
         2'b10:   level = LEVEL_MPEG2;
         default: level = LEVEL_MPEG25;
      endcase
      case (b1[2:1])
         2'b01:   layer = LAYER_3;
         2'b10:   layer = LAYER_2;
         2'b11:   layer = LAYER_1;
         default: layer = 2'd0;
      endcase
      row  = (level == LEVEL_MPEG1) ? ({1'b0, layer} - 3'd1) : ({1'b0, layer} + 3'd2);
      rate = rate_lookup(level, b2[3:2]);
      kbps = kbps_lookup(row, b2[7:4]);

      hdr_ok = (b0 == SYNC_BYTE) && ((b1 & SYNC_MASK) == SYNC_MASK) &&
               (b1[4:3] != 2'b01) && (b1[2:1] != 2'b00) &&
               (rate != 16'd0) && (kbps != 9'd0) &&
               !(match_enable_ff && (rate != match_rate_ff));

      hit_job                   = '0;
      hit_job.found             = 1'b1;
      hit_job.offset            = pos_ext[15:0];
      hit_job.version_level     = level;
      hit_job.layer             = layer;
      hit_job.crc_present       = ~b1[0];
      hit_job.padding           = b2[1];
      hit_job.private_bit       = b2[0];
      hit_job.mode_bits         = b3[7:4];
      hit_job.sample_rate       = rate;
      hit_job.bitrate_kbps      = kbps;
      if (layer == LAYER_1) begin
         hit_job.samples_per_frame = SPF_LAYER1;
      end else if ((layer == LAYER_2) || (level == LEVEL_MPEG1)) begin
         hit_job.samples_per_frame = SPF_LONG;
      end else begin
         hit_job.samples_per_frame = SPF_SHORT;
      end
   end

   always_comb begin
      window_in    = window_ff;
      count_in     = count_ff;
      searching_in = searching_ff;
      job_push     = 1'b0;
      job_data     = '0;
      if (accept && srch) begin
         searching_in = 1'b1;
         if (cnt < COUNT_BITS'(3)) begin
            window_in = {win[15:0], b3};
            count_in  = cnt + COUNT_BITS'(1);
         end else if (pos_ext > limit) begin
            window_in    = win;
            count_in     = cnt;
            searching_in = 1'b0;
            job_push     = 1'b1;
         end else begin
            window_in = {win[15:0], b3};
            count_in  = (cnt != '1) ? cnt + COUNT_BITS'(1) : cnt;
            if (hdr_ok) begin
               searching_in = 1'b0;
               job_push     = 1'b1;
               job_data     = hit_job;
            end else if (pos_ext >= limit) begin
               searching_in = 1'b0;
               job_push     = 1'b1;
            end
         end
      end
   end

   always_comb begin
      max_search_in   = max_search_ff;
      match_enable_in = match_enable_ff;
      match_rate_in   = match_rate_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAX_SEARCH:   max_search_in   = csr_wdata;
            CSR_MATCH_ENABLE: match_enable_in = csr_wdata[0];
            CSR_MATCH_RATE:   match_rate_in   = csr_wdata;
            default:          max_search_in   = max_search_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_search_ff   <= MAX_SEARCH_RESET;
         match_enable_ff <= 1'b0;
         match_rate_ff   <= MATCH_RATE_RESET;
         window_ff       <= 24'd0;
         count_ff        <= '0;
         searching_ff    <= 1'b0;
      end else begin
         max_search_ff   <= max_search_in;
         match_enable_ff <= match_enable_in;
         match_rate_ff   <= match_rate_in;
         window_ff       <= window_in;
         count_ff        <= count_in;
         searching_ff    <= searching_in;
      end
   end

endmodule
`default_nettype wire

>>> src/mahs_fifo.sv
// Short queue of classified items between the front and back parts.
`default_nettype none
module mahs_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mahs_pkg::rsp_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output mahs_pkg::rsp_type      pop_data,
   output logic                   empty
);
   import mahs_pkg::*;

   localparam int AW = $clog2(JOB_DEPTH);

   rsp_type     mem_ff [JOB_DEPTH];
   logic [AW:0] wptr_ff, wptr_in;
   logic [AW:0] rptr_ff, rptr_in;
   logic [AW:0] fill;

   assign fill     = wptr_ff - rptr_ff;
   assign full     = (fill == (AW+1)'(JOB_DEPTH));
   assign empty    = (fill == '0);
   assign pop_data = mem_ff[rptr_ff[AW-1:0]];

   always_comb begin
      wptr_in = (push && !full) ? wptr_ff + (AW+1)'(1) : wptr_ff;
      rptr_in = (pop && !empty) ? rptr_ff + (AW+1)'(1) : rptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wptr_ff[AW-1:0]] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> src/mahs_back.sv
// Back part: frame length by multiply and shift-subtract divide, and the result register.
`default_nettype none
module mahs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_empty,
   input  wire mahs_pkg::rsp_type job_data,
   output logic                   job_pop,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output mahs_pkg::rsp_type      rsp_data
);
   import mahs_pkg::*;

   localparam int CW = $clog2(NUM_BITS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL  = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CW-1:0]       step_ff, step_in;
   rsp_type             job_ff, job_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [15:0]         rem_ff, rem_in;
   logic [12:0]         quo_ff, quo_in;
   logic                out_valid_ff, out_valid_in;
   rsp_type             out_ff, out_in;

   logic [17:0]         coef;
   logic [16:0]         trial;
   logic                load_out;
   logic [12:0]         sum;

   assign job_pop   = (state_ff == S_IDLE) && !job_empty;
   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;
   assign load_out  = (state_ff == S_OUT) && (!out_valid_ff || rsp_pop);

   always_comb begin
      if (job_ff.layer == LAYER_1) begin
         coef = COEF_LAYER1;
      end else if ((job_ff.layer == LAYER_3) && (job_ff.version_level != LEVEL_MPEG1)) begin
         coef = COEF_SHORT;
      end else begin
         coef = COEF_LONG;
      end
      trial = {rem_ff, num_ff[NUM_BITS-1]};
      sum   = quo_ff + 13'(job_ff.padding);
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      job_in       = job_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      out_in       = out_ff;
      out_valid_in = (rsp_pop && out_valid_ff) ? 1'b0 : out_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (!job_empty) begin
               job_in   = job_data;
               state_in = job_data.found ? S_MUL : S_OUT;
            end
         end
         S_MUL: begin
            num_in   = NUM_BITS'(coef) * NUM_BITS'(job_ff.bitrate_kbps);
            rem_in   = 16'd0;
            quo_in   = 13'd0;
            step_in  = CW'(NUM_BITS);
            state_in = S_DIV;
         end
         S_DIV: begin
            num_in = num_ff << 1;
            if (trial >= {1'b0, job_ff.sample_rate}) begin
               rem_in = 16'(trial - {1'b0, job_ff.sample_rate});
               quo_in = {quo_ff[11:0], 1'b1};
            end else begin
               rem_in = trial[15:0];
               quo_in = {quo_ff[11:0], 1'b0};
            end
            step_in = step_ff - CW'(1);
            if (step_ff == CW'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (load_out) begin
               out_in = job_ff;
               if (job_ff.found) begin
                  out_in.frame_bytes = (job_ff.layer == LAYER_1) ? {sum[10:0], 2'b00} : sum;
               end
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      out_ff <= out_in;
   end

endmodule
`default_nettype wire

>>> src/mpeg_audio_header_sync_core.sv
// Top level of the MPEG audio frame header sync block.
//
// Input items are stream bytes on req_data; an item is taken when req_push is high and
// req_full is low. An item with first set opens a new search window at that byte.
// The front part takes one byte per cycle while req_full is low, keeps the last three
// bytes and checks each candidate header when its fourth byte arrives. A hit, or the end
// of the search window, puts one item into a four-entry queue. The back part computes
// the frame length with a 27-step shift-subtract divider before a found header reaches
// rsp_data; a window that runs out skips the divider and goes to the result register.
// Bytes keep flowing at one per cycle while results are pending; req_full rises only when
// the queue is full, which takes several results waiting on the divider or the receiver.
// A result stays on rsp_data while rsp_empty is low and is taken when rsp_pop is high.
// If the receiver stalls, the back part holds its finished item and then the queue fills.
// Reset clears the search, the queue and the result register and loads the defaults:
// search length 4096, matching off, required rate 44100. The user must write registers
// via csr_we, csr_index and csr_wdata only while idle; the block does not enforce it.
`default_nettype none
module mpeg_audio_header_sync_core #(
   parameter int COUNT_BITS = mahs_pkg::COUNT_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_push,
   output logic                                     req_full,
   input  wire mahs_pkg::req_type                   req_data,
   output logic                                     rsp_empty,
   input  wire logic                                rsp_pop,
   output mahs_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_we,
   input  wire logic [mahs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mahs_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import mahs_pkg::*;

   logic    job_push;
   rsp_type job_in_data;
   logic    job_full;
   logic    job_pop;
   rsp_type job_out_data;
   logic    job_empty;

   assign req_full = job_full;

   mahs_front #(
      .COUNT_BITS(COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_full  (job_full),
      .job_push  (job_push),
      .job_data  (job_in_data)
   );

   mahs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_data),
      .empty     (job_empty)
   );

   mahs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job_data  (job_out_data),
      .job_pop   (job_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> tb/sv/mpeg_audio_header_sync_core_tb.sv
// Self-checking testbench for the MPEG audio header sync core: directed rows, then random windows.
module mpeg_audio_header_sync_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mahs_pkg::*;

   localparam logic [1:0] VCODE_MPEG25   = 2'd0;
   localparam logic [1:0] VCODE_RESERVED = 2'd1;
   localparam logic [1:0] VCODE_MPEG2    = 2'd2;
   localparam logic [1:0] VCODE_MPEG1    = 2'd3;
   localparam logic [1:0] LCODE_RESERVED = 2'd0;
   localparam logic [1:0] FQ_RESERVED    = 2'd3;
   localparam logic [3:0] BRI_FREE       = 4'd0;
   localparam logic [3:0] BRI_BAD        = 4'd15;

   localparam int COUNT_SAT     = 65535;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 250;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int PHASE_BYTES   = 72;
   localparam int NUM_PHASES    = 8;
   localparam int DIRECTED_SPLIT = 5;

   localparam int PHASE_MS   [NUM_PHASES] = '{3, 5, 40, 65535, 200, 12, 65535, 20};
   localparam bit PHASE_MEN  [NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
   localparam int PHASE_RATE [NUM_PHASES] =
      '{44100, 48000, 22050, 0, 11025, 12345, 48000, 44100};

   localparam int RATE_MPEG1 [4] = '{44100, 48000, 32000, 0};
   localparam int RATE_LSF   [4] = '{22050, 24000, 16000, 0};
   localparam int KBPS_BY_ROW [6][16] = '{
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
   };

   typedef struct packed {
      logic [7:0] byte_val;
      logic       first;
      logic       miss;
   } stim_row;

   // Rows marked miss expect a result with found clear and every field zero.
   localparam stim_row DIRECTED [25] = '{
      '{8'hFF, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b0}, '{8'hFB, 1'b0, 1'b0}, '{8'h90, 1'b0, 1'b0}, '{8'h64, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b0}, '{8'hEB, 1'b0, 1'b0}, '{8'h90, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b0}, '{8'hF9, 1'b0, 1'b0}, '{8'h90, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b0}, '{8'hFB, 1'b0, 1'b0}, '{8'h9C, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b0}, '{8'hFB, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b0}, '{8'h00, 1'b0, 1'b1},
      '{8'hFF, 1'b1, 1'b0}, '{8'hFB, 1'b0, 1'b0}, '{8'hF0, 1'b0, 1'b0}, '{8'h5A, 1'b0, 1'b1}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_push = 1'b0;
   logic                      req_full;
   req_type                   req_data = '0;
   logic                      rsp_empty;
   logic                      rsp_pop = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_MAX_SEARCH;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int cfg_max_search = 4096;
   bit cfg_match_en   = 1'b0;
   int cfg_match_rate = 44100;

   logic [23:0] scan_window = '0;
   int          scan_count  = 0;
   bit          scan_active = 1'b0;

   rsp_type pending_frames[$];
   int cycle_count = 0;
   int hold_left = 0;
   int mismatch_count = 0;
   int bytes_used = 0;
   int windows_opened = 0;
   int frames_found = 0;
   int windows_exhausted = 0;
   bit sender_quick = 1'b0;

   mpeg_audio_header_sync_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   function automatic int code_rate(input logic [1:0] vcode, input logic [1:0] fq);
      int r;
      case (vcode)
         VCODE_MPEG1:  r = RATE_MPEG1[fq];
         VCODE_MPEG2:  r = RATE_LSF[fq];
         VCODE_MPEG25: r = RATE_LSF[fq] / 2;
         default:      r = 0;
      endcase
      return r;
   endfunction

   function automatic bit decode_frame(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input int ofs, output rsp_type hdr);
      logic [1:0] level;
      logic [1:0] layer;
      int rate;
      int kbps;
      int slots;
      int size;
      hdr = '0;
      if (b0 != SYNC_BYTE || (b1 & SYNC_MASK) != SYNC_MASK) return 1'b0;
      if (b1[4:3] == VCODE_RESERVED || b1[2:1] == LCODE_RESERVED) return 1'b0;
      level = (b1[4:3] == VCODE_MPEG1) ? LEVEL_MPEG1 :
              (b1[4:3] == VCODE_MPEG2) ? LEVEL_MPEG2 : LEVEL_MPEG25;
      layer = 2'd0 - b1[2:1];
      rate = code_rate(b1[4:3], b2[3:2]);
      if (rate == 0) return 1'b0;
      kbps = KBPS_BY_ROW[(level == LEVEL_MPEG1 ? 0 : 3) + int'(layer) - 1][b2[7:4]];
      if (kbps == 0) return 1'b0;
      if (cfg_match_en && rate != cfg_match_rate) return 1'b0;
      if (layer == LAYER_1) begin
         size = ((12000 * kbps) / rate + int'(b2[1])) * 4;
      end else begin
         slots = (layer == LAYER_3 && level != LEVEL_MPEG1) ? 72 : 144;
         size = (slots * kbps * 1000) / rate + int'(b2[1]);
      end
      hdr.found         = 1'b1;
      hdr.offset        = 16'(ofs);
      hdr.version_level = level;
      hdr.layer         = layer;
      hdr.crc_present   = ~b1[0];
      hdr.padding       = b2[1];
      hdr.private_bit   = b2[0];
      hdr.mode_bits     = b3[7:4];
      hdr.sample_rate   = 16'(rate);
      hdr.bitrate_kbps  = 9'(kbps);
      if (layer == LAYER_1) begin
         hdr.samples_per_frame = 11'd384;
      end else if (layer == LAYER_2 || level == LEVEL_MPEG1) begin
         hdr.samples_per_frame = 11'd1152;
      end else begin
         hdr.samples_per_frame = 11'd576;
      end
      hdr.frame_bytes = 13'(size);
      return 1'b1;
   endfunction

   // Advances the search state by one byte; returns 1 when the byte ends a search.
   function automatic bit sync_predict(input req_type it, output rsp_type hdr);
      int ofs;
      int last_ofs;
      bit hit;
      hdr = '0;
      if (it.first) begin
         scan_active = 1'b1;
         scan_count = 0;
         scan_window = '0;
         windows_opened++;
      end
      if (!scan_active) return 1'b0;
      if (scan_count < 3) begin
         scan_window = {scan_window[15:0], it.byte_in};
         scan_count++;
         return 1'b0;
      end
      ofs = scan_count - 3;
      last_ofs = (cfg_max_search < 5) ? 0 : cfg_max_search - 5;
      if (last_ofs > COUNT_SAT - 3) last_ofs = COUNT_SAT - 3;
      if (ofs > last_ofs) begin
         scan_active = 1'b0;
         return 1'b1;
      end
      hit = decode_frame(scan_window[23:16], scan_window[15:8], scan_window[7:0],
                         it.byte_in, ofs, hdr);
      scan_window = {scan_window[15:0], it.byte_in};
      if (scan_count < COUNT_SAT) scan_count++;
      if (hit) begin
         scan_active = 1'b0;
         return 1'b1;
      end
      if (ofs >= last_ofs) begin
         hdr = '0;
         scan_active = 1'b0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] noise_byte();
      return ($urandom_range(0, 5) == 0) ? SYNC_BYTE : 8'($urandom);
   endfunction

   // Builds a header, either well formed, matching the required rate where one fits, or with one defect.
   function automatic logic [31:0] make_frame_hdr(input bit well_formed);
      logic [1:0] vcodes [3];
      logic [1:0] vcode;
      logic [1:0] lcode;
      logic [1:0] fq;
      logic [3:0] bri;
      logic [7:0] b1;
      logic [7:0] b2;
      int tries;
      vcodes = '{VCODE_MPEG1, VCODE_MPEG2, VCODE_MPEG25};
      vcode = vcodes[$urandom_range(0, 2)];
      fq = 2'($urandom_range(0, 2));
      for (tries = 0; tries < 256 && cfg_match_en && code_rate(vcode, fq) != cfg_match_rate;
           tries++) begin
         vcode = vcodes[$urandom_range(0, 2)];
         fq = 2'($urandom_range(0, 2));
      end
      lcode = 2'($urandom_range(1, 3));
      bri = 4'($urandom_range(1, 14));
      b1 = 8'hFF;
      if (!well_formed) begin
         case ($urandom_range(0, 5))
            0: vcode = VCODE_RESERVED;
            1: lcode = LCODE_RESERVED;
            2: fq = FQ_RESERVED;
            3: bri = BRI_FREE;
            4: bri = BRI_BAD;
            default: b1[5 + $urandom_range(0, 2)] = 1'b0;
         endcase
      end
      b1 = {b1[7:5], vcode, lcode, 1'($urandom)};
      b2 = {bri, fq, 2'($urandom_range(0, 3))};
      return {SYNC_BYTE, b1, b2, 8'($urandom)};
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= 30) begin
         $display("Mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got,
                  want);
      end
   endtask

   task automatic check_frame(input rsp_type got);
      rsp_type want;
      if (pending_frames.size() == 0) begin
         report_mismatch("result with none expected, found", got.found, 0);
         return;
      end
      want = pending_frames.pop_front();
      if (want.found) frames_found++;
      else windows_exhausted++;
      if (got.found != want.found) report_mismatch("found", got.found, want.found);
      if (got.offset != want.offset) report_mismatch("offset", got.offset, want.offset);
      if (got.version_level != want.version_level) begin
         report_mismatch("version_level", got.version_level, want.version_level);
      end
      if (got.layer != want.layer) report_mismatch("layer", got.layer, want.layer);
      if (got.crc_present != want.crc_present) begin
         report_mismatch("crc_present", got.crc_present, want.crc_present);
      end
      if (got.padding != want.padding) report_mismatch("padding", got.padding, want.padding);
      if (got.private_bit != want.private_bit) begin
         report_mismatch("private_bit", got.private_bit, want.private_bit);
      end
      if (got.mode_bits != want.mode_bits) begin
         report_mismatch("mode_bits", got.mode_bits, want.mode_bits);
      end
      if (got.sample_rate != want.sample_rate) begin
         report_mismatch("sample_rate", got.sample_rate, want.sample_rate);
      end
      if (got.bitrate_kbps != want.bitrate_kbps) begin
         report_mismatch("bitrate_kbps", got.bitrate_kbps, want.bitrate_kbps);
      end
      if (got.samples_per_frame != want.samples_per_frame) begin
         report_mismatch("samples_per_frame", got.samples_per_frame, want.samples_per_frame);
      end
      if (got.frame_bytes != want.frame_bytes) begin
         report_mismatch("frame_bytes", got.frame_bytes, want.frame_bytes);
      end
   endtask

   task automatic push_byte(input req_type it, input bit typed_miss);
      int gap;
      bit used;
      bit ended;
      rsp_type hdr;
      gap = sender_quick ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_full);
      used = scan_active || it.first;
      ended = sync_predict(it, hdr);
      if (used) bytes_used++;
      if (typed_miss) begin
         pending_frames.push_back('0);
      end else if (ended) begin
         pending_frames.push_back(hdr);
      end
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input int max_search, input bit match_en, input int match_rate);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= CSR_MAX_SEARCH;
      csr_wdata <= 16'(max_search);
      @(posedge clock);
      cfg_max_search = max_search;
      csr_index <= CSR_MATCH_ENABLE;
      csr_wdata <= 16'(match_en);
      @(posedge clock);
      cfg_match_en = match_en;
      csr_index <= CSR_MATCH_RATE;
      csr_wdata <= 16'(match_rate);
      @(posedge clock);
      cfg_match_rate = match_rate;
      csr_we <= 1'b0;
   endtask

   // One search window: noise, a header, noise until the search ends; may stop early or add noise.
   task automatic run_window(input bit must_finish);
      int limit;
      int hdr_at;
      int n;
      bit quit_early;
      logic [31:0] hdr;
      limit = (cfg_max_search < 5) ? 0 : cfg_max_search - 5;
      hdr_at = $urandom_range(0, (limit < 30) ? limit : 30);
      hdr = make_frame_hdr(limit > 60 || $urandom_range(0, 9) < 7);
      quit_early = !must_finish && $urandom_range(0, 9) == 0;
      sender_quick = ($urandom_range(0, 3) == 0);
      for (n = 0; n < hdr_at; n++) begin
         push_byte({noise_byte(), n == 0}, 1'b0);
      end
      for (n = 0; n < 4; n++) begin
         if (quit_early && n == 2) return;
         push_byte({hdr[31 - 8 * n -: 8], hdr_at == 0 && n == 0}, 1'b0);
      end
      while (scan_active) push_byte({noise_byte(), 1'b0}, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 3)) push_byte({noise_byte(), 1'b0}, 1'b0);
      end
   endtask

   initial begin
      int gap;
      int taken;
      while (reset) @(posedge clock);
      taken = 0;
      gap = 0;
      forever begin
         if (taken % 16 == 0) gap = ($urandom_range(0, 2) == 0) ? 0 : 9;
         if ((gap == 0 ? 0 : $urandom_range(0, 8)) > 0 || hold_left != 0) begin
            rsp_pop <= 1'b0;
            repeat ((gap == 0) ? 1 : $urandom_range(1, 8)) @(posedge clock);
            while (hold_left != 0) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         check_frame(rsp_data);
         taken++;
      end
   end

   initial begin
      int i;
      int p;
      int phase_start;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_SPLIT; i++) begin
         push_byte({DIRECTED[i].byte_val, DIRECTED[i].first}, DIRECTED[i].miss);
      end
      // A search length below the minimum tries offset zero only.
      write_regs(3, 1'b0, 44100);
      for (i = DIRECTED_SPLIT; i < 25; i++) begin
         push_byte({DIRECTED[i].byte_val, DIRECTED[i].first}, DIRECTED[i].miss);
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         write_regs(PHASE_MS[p], PHASE_MEN[p], PHASE_RATE[p]);
         if (p == 0) hold_left <= HOLD_CYCLES;
         phase_start = bytes_used;
         while (bytes_used - phase_start < PHASE_BYTES) run_window(1'b0);
         run_window(1'b1);
      end

      wait_idle();
      if (pending_frames.size() != 0) begin
         report_mismatch("results never delivered", pending_frames.size(), 0);
      end
      $display("Sent %0d stream bytes across %0d search windows under %0d register settings.",
               bytes_used, windows_opened, NUM_PHASES + 2);
      $display("Headers found: %0d, windows run out: %0d, mismatches: %0d.",
               frames_found, windows_exhausted, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
